// ===== hdl/modexp_pkg.sv =====
package modexp_pkg;

  localparam int OPERAND_BITS = 31;
  localparam int FIELD_W      = 31;
  localparam int CNT_W        = $clog2(OPERAND_BITS + 1);

  localparam logic ACT_POWER   = 1'b0;
  localparam logic ACT_INVERSE = 1'b1;

  typedef logic [OPERAND_BITS-1:0] opnd_t;
  typedef logic [FIELD_W-1:0]      field_t;

endpackage

// ===== hdl/modexp_if.sv =====
interface modexp_req_if;
  logic                   valid;
  logic                   ready;
  logic                   action;
  modexp_pkg::field_t     base_value;
  modexp_pkg::field_t     exponent;
  modexp_pkg::field_t     modulus;

  modport source (output valid, action, base_value, exponent, modulus, input ready);
  modport sink   (input valid, action, base_value, exponent, modulus, output ready);
endinterface

interface modexp_rsp_if;
  logic                   valid;
  logic                   ready;
  modexp_pkg::field_t     result;

  modport source (output valid, result, input ready);
  modport sink   (input valid, result, output ready);
endinterface

// ===== hdl/modexp_mulmod.sv =====
module modexp_mulmod (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  modexp_pkg::opnd_t x,
  input  modexp_pkg::opnd_t y,
  input  modexp_pkg::opnd_t m,
  output logic              done,
  output modexp_pkg::opnd_t product
);

  localparam int W = modexp_pkg::OPERAND_BITS;

  modexp_pkg::opnd_t              xs;
  modexp_pkg::opnd_t              r;
  modexp_pkg::opnd_t              r_next;
  logic [modexp_pkg::CNT_W-1:0]   cnt;
  logic                           busy;
  logic [W+2:0]                   t;
  logic [W+2:0]                   d1;
  logic [W+2:0]                   d2;

  // Double, add y on a set multiplier bit, then bring the sum below m (it stays below 3m)
  always_comb begin
    t  = {2'b00, r, 1'b0} + (xs[W-1] ? {3'b000, y} : {(W+3){1'b0}});
    d1 = t - {3'b000, m};
    d2 = t - {2'b00, m, 1'b0};
    if (!d2[W+2]) begin
      r_next = d2[W-1:0];
    end else if (!d1[W+2]) begin
      r_next = d1[W-1:0];
    end else begin
      r_next = t[W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= busy && !start && cnt == modexp_pkg::CNT_W'(1);
      if (start) begin
        busy <= 1'b1;
      end else if (busy && cnt == modexp_pkg::CNT_W'(1)) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      xs  <= x;
      r   <= '0;
      cnt <= modexp_pkg::CNT_W'(W);
    end else if (busy) begin
      xs  <= xs << 1;
      r   <= r_next;
      cnt <= cnt - 1'b1;
    end
  end

  assign product = r;

  a_partial_reduced: assert property (@(posedge clk) disable iff (rst)
    busy && !start |-> r < m || m == '0)
    else $error("partial product not reduced");

endmodule

// ===== hdl/modular_exponentiation.sv =====
// Channel  Dir  Fields                                    Transfer
// req      in   action, base_value, exponent, modulus     valid && ready
// rsp      out  result                                    valid && ready
//
// One item at a time; the next item is taken while a result still waits in rsp.
// Each modular product runs bit-serially. A zero exponent, a zero modulus, or an
// inverse with a modulus of at most 2 skips the products.
// Reset (rst, synchronous) empties the block and drops any waiting result.
// A stalled rsp holds the result; work on the next item pauses only at its end.
module modular_exponentiation (
  input  logic             clk,
  input  logic             rst,
  modexp_req_if.sink       req,
  modexp_rsp_if.source     rsp
);

  localparam int W = modexp_pkg::OPERAND_BITS;

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_REDUCE = 2'd1;
  localparam logic [1:0] ST_STEP   = 2'd2;
  localparam logic [1:0] ST_DONE   = 2'd3;

  logic [1:0]          state;
  modexp_pkg::opnd_t   acc;
  modexp_pkg::opnd_t   b;
  modexp_pkg::opnd_t   e;
  modexp_pkg::opnd_t   m;
  logic                mul_start;
  logic                res_valid;
  modexp_pkg::field_t  res;

  modexp_pkg::opnd_t   in_b;
  modexp_pkg::opnd_t   in_e;
  modexp_pkg::opnd_t   in_m;
  modexp_pkg::opnd_t   eff_e;
  logic                is_inv;
  logic                accept;
  logic                skip_mul;

  modexp_pkg::opnd_t   mul_y;
  modexp_pkg::opnd_t   sqr_y;
  modexp_pkg::opnd_t   prod_a;
  modexp_pkg::opnd_t   prod_b;
  logic                a_done;
  logic                b_done;
  logic                mul_done;

  assign in_b   = req.base_value[W-1:0];
  assign in_e   = req.exponent[W-1:0];
  assign in_m   = req.modulus[W-1:0];
  assign is_inv = (req.action == modexp_pkg::ACT_INVERSE);
  assign eff_e  = is_inv ? in_m - modexp_pkg::opnd_t'(2) : in_e;

  assign skip_mul = (is_inv && in_m <= modexp_pkg::opnd_t'(2)) || (!is_inv && in_e == '0) ||
                    (in_m == '0);

  assign req.ready = (state == ST_IDLE);
  assign accept    = req.valid && req.ready;

  // Reduce pass multiplies the raw base by one; the step pass multiplies by acc
  assign mul_y    = (state == ST_REDUCE) ? modexp_pkg::opnd_t'(1) : acc;
  // Keep the squaring unit on a reduced operand while the raw base is reduced
  assign sqr_y    = (state == ST_REDUCE) ? modexp_pkg::opnd_t'(1) : b;
  assign mul_done = a_done & b_done;

  modexp_mulmod u_mul_acc (
    .clk     (clk),
    .rst     (rst),
    .start   (mul_start),
    .x       (b),
    .y       (mul_y),
    .m       (m),
    .done    (a_done),
    .product (prod_a)
  );

  modexp_mulmod u_mul_sqr (
    .clk     (clk),
    .rst     (rst),
    .start   (mul_start),
    .x       (b),
    .y       (sqr_y),
    .m       (m),
    .done    (b_done),
    .product (prod_b)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      mul_start <= 1'b0;
      res_valid <= 1'b0;
    end else begin
      // Load a finished result, or drop the one just transferred
      if (state == ST_DONE && (!res_valid || rsp.ready)) begin
        res_valid <= 1'b1;
      end else if (rsp.valid && rsp.ready) begin
        res_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          mul_start <= accept && !skip_mul;
          if (accept) begin
            state <= skip_mul ? ST_DONE : ST_REDUCE;
          end
        end
        ST_REDUCE: begin
          mul_start <= mul_done;
          if (mul_done) begin
            state <= ST_STEP;
          end
        end
        ST_STEP: begin
          mul_start <= mul_done && (e[W-1:1] != '0);
          if (mul_done && e[W-1:1] == '0) begin
            state <= ST_DONE;
          end
        end
        ST_DONE: begin
          mul_start <= 1'b0;
          // Hold until the output register is free
          if (!res_valid || rsp.ready) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          mul_start <= 1'b0;
          state     <= ST_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        if (accept) begin
          b <= in_b;
          e <= eff_e;
          m <= in_m;
          if ((is_inv && in_m <= modexp_pkg::opnd_t'(2)) || (!is_inv && in_e == '0)) begin
            acc <= modexp_pkg::opnd_t'(1);
          end else if (in_m == '0) begin
            acc <= '0;
          end else begin
            acc <= modexp_pkg::opnd_t'(1);
          end
        end
      end
      ST_REDUCE: begin
        if (mul_done) begin
          b <= prod_a;
        end
      end
      ST_STEP: begin
        if (mul_done) begin
          if (e[0]) begin
            acc <= prod_a;
          end
          b <= prod_b;
          e <= e >> 1;
        end
      end
      ST_DONE: begin
        if (!res_valid || rsp.ready) begin
          res <= modexp_pkg::field_t'(acc);
        end
      end
      default: ;
    endcase
  end

  assign rsp.valid  = res_valid;
  assign rsp.result = res;

  a_done_pair: assert property (@(posedge clk) disable iff (rst)
    a_done == b_done)
    else $error("multipliers out of step");

  a_done_phase: assert property (@(posedge clk) disable iff (rst)
    a_done |-> state == ST_REDUCE || state == ST_STEP)
    else $error("product arrived outside a multiply phase");

  a_step_exp: assert property (@(posedge clk) disable iff (rst)
    state == ST_STEP |-> e != '0)
    else $error("exponent exhausted while stepping");

  a_step_base: assert property (@(posedge clk) disable iff (rst)
    state == ST_STEP |-> b < m)
    else $error("base not reduced before stepping");

endmodule
